FILE: rtl/mono_last_note_priority_voicer_unit_macros.svh
// Assertion shorthands for the voicer: clocked on clk, quiet during reset.
`ifndef MONO_LAST_NOTE_PRIORITY_VOICER_UNIT_MACROS_SVH
`define MONO_LAST_NOTE_PRIORITY_VOICER_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define MLNPV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define MLNPV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mlnpv_pkg.sv
package mlnpv_pkg;

    // Sizing
    localparam int STACK_DEPTH = 16;
    localparam int VOICES      = 3;
    localparam int MAX_RESULTS = 3;
    localparam int PITCH_MIN   = 1;
    localparam int PITCH_MAX   = 99;

    // Field widths
    localparam int OP_W    = 2;
    localparam int CH_W    = 4;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int VOICE_W = 2;
    localparam int PITCH_W = 7;
    localparam int OFF_W   = 8;
    localparam int DIFF_W  = NOTE_W + 3;

    // Derived widths
    localparam int IDX_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ADDR_W    = VIDX_W + IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int RES_W     = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [OP_W-1:0] OP_ALL_OFF  = 2'd2;

    typedef logic [NOTE_W-1:0]  note_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [VIDX_W-1:0]  vidx_t;
    typedef logic [VOICE_W-1:0] voice_t;
    typedef logic [RES_W-1:0]   res_cnt_t;
    typedef logic [CH_W:0]      chx_t;
    typedef logic [ADDR_W-1:0]  addr_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CH_W-1:0]  channel;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0] velocity;
    } in_item_t;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic               gate;
        logic               retrigger;
        logic [PITCH_W-1:0] pitch;
        logic [NOTE_W-1:0]  source_note;
        logic [VEL_W-1:0]   out_velocity;
        logic               last;
    } out_item_t;

endpackage

FILE: rtl/mlnpv_ram.sv
module mlnpv_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register one read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/mono_last_note_priority_voicer_unit.sv
// Note on: the stack of that voice is scanned and compacted to take the note out; a note on
// to a full stack drops the oldest entry in a second pass; then the note is pushed and registered.
// Note off: the scan takes the note out; only an off that removes the top note gives a result.
// All notes off: one release per busy voice, lowest voice first, issued while the output is free.
// The input stalls until the item is done; the scan compares one stack entry per cycle.
// Reset clears counts, offset, output.
`include "mono_last_note_priority_voicer_unit_macros.svh"

module mono_last_note_priority_voicer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  mlnpv_pkg::in_item_t           in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output mlnpv_pkg::out_item_t          out_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mlnpv_pkg::OFF_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUSH,
        ST_EMIT,
        ST_ALLOFF
    } state_t;

    state_t                          state_reg, state_next;
    logic [mlnpv_pkg::OFF_W-1:0]     off_reg, off_next;
    mlnpv_pkg::cnt_t                 held_count_reg [mlnpv_pkg::VOICES];
    mlnpv_pkg::cnt_t                 held_count_next [mlnpv_pkg::VOICES];
    logic                            is_on_reg, is_on_next;
    mlnpv_pkg::vidx_t                vidx_reg, vidx_next;
    mlnpv_pkg::note_t                note_reg, note_next;
    logic [mlnpv_pkg::VEL_W-1:0]     vel_reg, vel_next;
    mlnpv_pkg::cnt_t                 rd_idx_reg, rd_idx_next;
    mlnpv_pkg::cnt_t                 wr_idx_reg, wr_idx_next;
    mlnpv_pkg::cnt_t                 pass_cnt_reg, pass_cnt_next;
    logic                            pend_reg, pend_next;
    logic                            pend_first_reg, pend_first_next;
    logic                            pend_last_reg, pend_last_next;
    logic                            drop_reg, drop_next;
    logic                            was_reg, was_next;
    logic                            active_reg, active_next;
    mlnpv_pkg::note_t                kept_reg, kept_next;
    mlnpv_pkg::out_item_t            res_reg, res_next;
    logic [mlnpv_pkg::VOICES-1:0]    mask_reg, mask_next;
    mlnpv_pkg::res_cnt_t             emit_cnt_reg, emit_cnt_next;
    logic                            out_valid_reg, out_valid_next;
    mlnpv_pkg::out_item_t            out_item_reg, out_item_next;

    // RAM port
    logic                            mem_wr_en;
    mlnpv_pkg::addr_t                mem_wr_addr;
    mlnpv_pkg::note_t                mem_wr_data;
    logic                            mem_rd_en;
    mlnpv_pkg::addr_t                mem_rd_addr;
    mlnpv_pkg::note_t                mem_rd_data;

    // Shared clamp unit
    mlnpv_pkg::note_t                clamp_src;
    logic signed [mlnpv_pkg::DIFF_W-1:0] diff;
    logic [mlnpv_pkg::PITCH_W-1:0]   clamped;

    logic                            accept;
    logic                            out_free;
    logic                            ch_ok;
    mlnpv_pkg::vidx_t                in_vidx;
    mlnpv_pkg::cnt_t                 in_cnt;
    logic                            keep;
    mlnpv_pkg::vidx_t                low_vidx;
    logic [mlnpv_pkg::VOICES-1:0]    rest_mask;
    logic                            fin;
    logic                            count_ok;

    mlnpv_ram #(
        .WIDTH  (mlnpv_pkg::NOTE_W),
        .DEPTH  (mlnpv_pkg::MEM_DEPTH),
        .ADDR_W (mlnpv_pkg::ADDR_W)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

    assign in_vidx = in_item.channel[mlnpv_pkg::VIDX_W-1:0];
    assign ch_ok   = ({1'b0, in_item.channel} < mlnpv_pkg::chx_t'(mlnpv_pkg::VOICES));

    // Clamp note minus offset into the pitch range
    always_comb
    begin
        clamp_src = (state_reg == ST_PUSH) ? note_reg : kept_reg;
        diff = $signed({3'b000, clamp_src}) - $signed({{2{off_reg[mlnpv_pkg::OFF_W-1]}}, off_reg});
        if (diff < $signed(mlnpv_pkg::DIFF_W'(mlnpv_pkg::PITCH_MIN)))
        begin
            clamped = mlnpv_pkg::PITCH_W'(mlnpv_pkg::PITCH_MIN);
        end
        else if (diff > $signed(mlnpv_pkg::DIFF_W'(mlnpv_pkg::PITCH_MAX)))
        begin
            clamped = mlnpv_pkg::PITCH_W'(mlnpv_pkg::PITCH_MAX);
        end
        else
        begin
            clamped = diff[mlnpv_pkg::PITCH_W-1:0];
        end
    end

    // Pick the lowest busy voice for all notes off
    always_comb
    begin
        low_vidx = '0;
        for (int v = mlnpv_pkg::VOICES - 1; v >= 0; v--)
        begin
            if (mask_reg[v])
            begin
                low_vidx = mlnpv_pkg::vidx_t'(v);
            end
        end
        rest_mask = mask_reg;
        rest_mask[low_vidx] = 1'b0;
        fin = (rest_mask == '0) ||
              (emit_cnt_reg == mlnpv_pkg::res_cnt_t'(mlnpv_pkg::MAX_RESULTS - 1));
    end

    assign in_cnt = held_count_reg[in_vidx];
    assign keep   = (mem_rd_data != note_reg) && !(drop_reg && pend_first_reg);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        off_next        = off_reg;
        held_count_next = held_count_reg;
        is_on_next      = is_on_reg;
        vidx_next       = vidx_reg;
        note_next       = note_reg;
        vel_next        = vel_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        pass_cnt_next   = pass_cnt_reg;
        pend_next       = pend_reg;
        pend_first_next = pend_first_reg;
        pend_last_next  = pend_last_reg;
        drop_next       = drop_reg;
        was_next        = was_reg;
        active_next     = active_reg;
        kept_next       = kept_reg;
        res_next        = res_reg;
        mask_next       = mask_reg;
        emit_cnt_next   = emit_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = {vidx_reg, wr_idx_reg[mlnpv_pkg::IDX_W-1:0]};
        mem_wr_data     = note_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = {vidx_reg, rd_idx_reg[mlnpv_pkg::IDX_W-1:0]};

        // Take the offset register
        if (cfg_valid)
        begin
            off_next = cfg_data;
        end

        // Drop the output item once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_item.op)
                        mlnpv_pkg::OP_NOTE_ON, mlnpv_pkg::OP_NOTE_OFF:
                        begin
                            if (ch_ok && !(in_item.op == mlnpv_pkg::OP_NOTE_OFF &&
                                           in_cnt == '0))
                            begin
                                is_on_next    = (in_item.op == mlnpv_pkg::OP_NOTE_ON);
                                vidx_next     = in_vidx;
                                note_next     = in_item.note;
                                vel_next      = in_item.velocity;
                                was_next      = (in_cnt != '0);
                                pass_cnt_next = in_cnt;
                                rd_idx_next   = '0;
                                wr_idx_next   = '0;
                                pend_next     = 1'b0;
                                drop_next     = 1'b0;
                                active_next   = 1'b0;
                                state_next    = ST_SCAN;
                            end
                        end
                        mlnpv_pkg::OP_ALL_OFF:
                        begin
                            for (int v = 0; v < mlnpv_pkg::VOICES; v++)
                            begin
                                mask_next[v]       = (held_count_reg[v] != '0);
                                held_count_next[v] = '0;
                            end
                            emit_cnt_next = '0;
                            if (mask_next != '0)
                            begin
                                state_next = ST_ALLOFF;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Compare the entry read last cycle and compact it down
                if (pend_reg)
                begin
                    if (keep)
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = mem_rd_data;
                        wr_idx_next = wr_idx_reg + 1'b1;
                        kept_next   = mem_rd_data;
                    end
                    if (pend_last_reg)
                    begin
                        active_next = (mem_rd_data == note_reg);
                    end
                end

                // Issue the next read
                if (rd_idx_reg != pass_cnt_reg)
                begin
                    mem_rd_en       = 1'b1;
                    pend_next       = 1'b1;
                    pend_first_next = (rd_idx_reg == '0);
                    pend_last_next  = (mlnpv_pkg::cnt_t'(rd_idx_reg + 1'b1) == pass_cnt_reg);
                    rd_idx_next     = rd_idx_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // Finish the pass
                if (rd_idx_reg == pass_cnt_reg && !pend_reg)
                begin
                    if (is_on_reg)
                    begin
                        if (!drop_reg &&
                            wr_idx_reg == mlnpv_pkg::cnt_t'(mlnpv_pkg::STACK_DEPTH))
                        begin
                            drop_next     = 1'b1;
                            pass_cnt_next = wr_idx_reg;
                            rd_idx_next   = '0;
                            wr_idx_next   = '0;
                        end
                        else
                        begin
                            state_next = ST_PUSH;
                        end
                    end
                    else
                    begin
                        held_count_next[vidx_reg] = wr_idx_reg;
                        if (active_reg)
                        begin
                            res_next.voice        = mlnpv_pkg::voice_t'(vidx_reg);
                            res_next.gate         = (wr_idx_reg != '0);
                            res_next.retrigger    = 1'b0;
                            res_next.pitch        = (wr_idx_reg != '0) ? clamped : '0;
                            res_next.source_note  = (wr_idx_reg != '0) ? kept_reg : note_reg;
                            res_next.out_velocity = '0;
                            res_next.last         = 1'b1;
                            state_next            = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_PUSH:
            begin
                // Push the note on top and gate the voice
                mem_wr_en                 = 1'b1;
                mem_wr_data               = note_reg;
                held_count_next[vidx_reg] = wr_idx_reg + 1'b1;
                res_next.voice            = mlnpv_pkg::voice_t'(vidx_reg);
                res_next.gate             = 1'b1;
                res_next.retrigger        = !was_reg;
                res_next.pitch            = clamped;
                res_next.source_note      = note_reg;
                res_next.out_velocity     = vel_reg;
                res_next.last             = 1'b1;
                state_next                = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            ST_ALLOFF:
            begin
                // Release one busy voice per cycle while the output is free
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next              = '0;
                    out_item_next.voice        = mlnpv_pkg::voice_t'(low_vidx);
                    out_item_next.last         = fin;
                    mask_next                  = rest_mask;
                    emit_cnt_next              = emit_cnt_reg + 1'b1;
                    if (fin)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            off_reg        <= '0;
            held_count_reg <= '{default: '0};
            is_on_reg      <= 1'b0;
            vidx_reg       <= '0;
            note_reg       <= '0;
            vel_reg        <= '0;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            pass_cnt_reg   <= '0;
            pend_reg       <= 1'b0;
            pend_first_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            drop_reg       <= 1'b0;
            was_reg        <= 1'b0;
            active_reg     <= 1'b0;
            kept_reg       <= '0;
            res_reg        <= '0;
            mask_reg       <= '0;
            emit_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            off_reg        <= off_next;
            held_count_reg <= held_count_next;
            is_on_reg      <= is_on_next;
            vidx_reg       <= vidx_next;
            note_reg       <= note_next;
            vel_reg        <= vel_next;
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
            pass_cnt_reg   <= pass_cnt_next;
            pend_reg       <= pend_next;
            pend_first_reg <= pend_first_next;
            pend_last_reg  <= pend_last_next;
            drop_reg       <= drop_next;
            was_reg        <= was_next;
            active_reg     <= active_next;
            kept_reg       <= kept_next;
            res_reg        <= res_next;
            mask_reg       <= mask_next;
            emit_cnt_reg   <= emit_cnt_next;
            out_valid_reg  <= out_valid_next;
            out_item_reg   <= out_item_next;
        end
    end

    // Every held count stays within the stack
    always_comb
    begin
        count_ok = 1'b1;
        for (int v = 0; v < mlnpv_pkg::VOICES; v++)
        begin
            if (held_count_reg[v] > mlnpv_pkg::cnt_t'(mlnpv_pkg::STACK_DEPTH))
            begin
                count_ok = 1'b0;
            end
        end
    end

    `MLNPV_ASSERT_NOW(a_count_in_range, 1'b1, count_ok, "held count beyond stack depth")
    `MLNPV_ASSERT_NOW(a_compact_behind_read, state_reg == ST_SCAN, wr_idx_reg <= rd_idx_reg, "compaction write overtook read")
    `MLNPV_ASSERT_NOW(a_result_limit, state_reg == ST_ALLOFF, emit_cnt_reg < mlnpv_pkg::res_cnt_t'(mlnpv_pkg::MAX_RESULTS), "too many releases")
    `MLNPV_ASSERT_NEXT(a_push_holds_note, state_reg == ST_PUSH, held_count_reg[vidx_reg] != '0, "push left voice empty")

endmodule
